@@ rtl/rtc_bcd_utc_to_local_datetime_macros.svh @@
// Assertion macros for the RTC BCD to local date and time block.
`ifndef RTC_BCD_UTC_TO_LOCAL_DATETIME_MACROS_SVH
`define RTC_BCD_UTC_TO_LOCAL_DATETIME_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTCBCD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTCBCD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rtcbcd_pkg.sv @@
// Types, constants and decode functions for the RTC BCD to local date and time block.
package rtcbcd_pkg;

   localparam logic [2:0]  REG_TIMEZONE = 3'd0;
   localparam logic [11:0] YEAR_BASE    = 12'd2000;
   localparam logic [11:0] YEAR_FORCED  = 12'd2024;
   localparam logic [6:0]  YEAR_MIN_YY  = 7'd20;

   typedef struct packed {
      logic [7:0] year_bcd;
      logic [7:0] month_bcd;
      logic [7:0] date_bcd;
      logic [7:0] hours_bcd;
      logic [7:0] minutes_bcd;
      logic [7:0] seconds_bcd;
   } req_item_type;

   typedef struct packed {
      logic [11:0] local_year;
      logic [3:0]  local_month;
      logic [4:0]  local_day;
      logic [4:0]  local_hour;
      logic [5:0]  local_minute;
      logic [5:0]  local_second;
   } rsp_item_type;

   // tens*10 + units, either nibble up to 15
   function automatic logic [7:0] bcd_dec(input logic [7:0] v);
      logic [7:0] t;
      t = {4'b0000, v[7:4]};
      return (t << 3) + (t << 1) + {4'b0000, v[3:0]};
   endfunction

   // years seen here lie in 2019..2099
   function automatic logic is_leap(input logic [11:0] y);
      return (y[1:0] == 2'b00) && (y != 12'd2100);
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] d;
      unique case (m)
         4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
         4'd2:                    d = leap ? 5'd29 : 5'd28;
         default:                 d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

@@ rtl/rtc_bcd_utc_to_local_datetime.sv @@
// Top level: RTC BCD snapshot to local date and time with timezone carry.
// An accepted item passes the input register, then the result register, to rsp_tvalid.
// Throughput: one item per cycle while rsp_tready does not stall the output; decode
// and day/month/year carry are one combinational pass between the two registers.
// Reset: synchronous, active high; clears both valid flags and sets the
// timezone offset to 0.
`include "rtc_bcd_utc_to_local_datetime_macros.svh"

module rtc_bcd_utc_to_local_datetime
   import rtcbcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // seconds_bcd, minutes_bcd, hours_bcd, date_bcd, month_bcd, year_bcd
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // local_second, local_minute, local_hour, local_day, local_month, local_year, 2'b0
   output logic [39:0] rsp_tdata,
   // year_forced
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic signed [4:0] tz_ff, tz_in;
   logic              s1_valid_ff, s1_valid_in;
   req_item_type      s1_item_ff, s1_item_in;
   logic              out_valid_ff, out_valid_in;
   rsp_item_type      out_item_ff, out_item_in;
   logic              out_forced_ff, out_forced_in;

   logic              out_open;
   logic              s1_move;
   logic              req_take;
   logic              csr_write;

   logic [7:0]        sec_d, min_d, hr_d, day_d, mon_d, yy_d;
   logic [5:0]        sec_v, min_v;
   logic [4:0]        hr_v, day_v;
   logic [3:0]        mon_v, mon_prev;
   logic [6:0]        yy_v;
   logic [11:0]       year_v, year_prev;
   logic              forced_v;
   logic signed [6:0] hsum;
   logic [5:0]        day_inc;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = {{27{tz_ff[4]}}, tz_ff};
   assign tz_in      = (csr_write && (csr_paddr[2] == REG_TIMEZONE[2])) ?
                       $signed(csr_pwdata[4:0]) : tz_ff;

   assign out_open   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_open;
   assign req_tready = !s1_valid_ff || out_open;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign s1_item_in   = req_take ? req_item_type'(req_tdata) : s1_item_ff;
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_tready);

   always_comb begin
      sec_d = bcd_dec(s1_item_ff.seconds_bcd);
      min_d = bcd_dec(s1_item_ff.minutes_bcd);
      hr_d  = bcd_dec({2'b00, s1_item_ff.hours_bcd[5:0]});
      day_d = bcd_dec(s1_item_ff.date_bcd);
      mon_d = bcd_dec({1'b0, s1_item_ff.month_bcd[6:0]});
      yy_d  = bcd_dec(s1_item_ff.year_bcd);

      sec_v = (sec_d > 8'd59) ? 6'd59 : sec_d[5:0];
      min_v = (min_d > 8'd59) ? 6'd59 : min_d[5:0];
      hr_v  = (hr_d > 8'd23) ? 5'd23 : hr_d[4:0];
      day_v = (day_d > 8'd31) ? 5'd31 : ((day_d == 8'd0) ? 5'd1 : day_d[4:0]);
      mon_v = (mon_d > 8'd12) ? 4'd12 : ((mon_d == 8'd0) ? 4'd1 : mon_d[3:0]);
      yy_v  = (yy_d > 8'd99) ? 7'd99 : yy_d[6:0];

      forced_v = !s1_item_ff.month_bcd[7] || (yy_v < YEAR_MIN_YY);
      year_v   = forced_v ? YEAR_FORCED : (YEAR_BASE + {5'd0, yy_v});

      hsum      = $signed({2'b00, hr_v}) + $signed({{2{tz_ff[4]}}, tz_ff});
      day_inc   = {1'b0, day_v} + 6'd1;
      mon_prev  = (mon_v == 4'd1) ? 4'd12 : (mon_v - 4'd1);
      year_prev = (mon_v == 4'd1) ? (year_v - 12'd1) : year_v;

      out_item_in.local_second = sec_v;
      out_item_in.local_minute = min_v;
      out_item_in.local_hour   = hsum[4:0];
      out_item_in.local_day    = day_v;
      out_item_in.local_month  = mon_v;
      out_item_in.local_year   = year_v;

      if (hsum >= 7'sd24) begin
         out_item_in.local_hour = 5'(hsum - 7'sd24);
         if (day_inc > {1'b0, month_days(mon_v, is_leap(year_v))}) begin
            out_item_in.local_day = 5'd1;
            if (mon_v == 4'd12) begin
               out_item_in.local_month = 4'd1;
               out_item_in.local_year  = year_v + 12'd1;
            end else begin
               out_item_in.local_month = mon_v + 4'd1;
            end
         end else begin
            out_item_in.local_day = day_inc[4:0];
         end
      end else if (hsum < 7'sd0) begin
         out_item_in.local_hour = 5'(hsum + 7'sd24);
         if (day_v == 5'd1) begin
            out_item_in.local_month = mon_prev;
            out_item_in.local_year  = year_prev;
            out_item_in.local_day   = month_days(mon_prev, is_leap(year_prev));
         end else begin
            out_item_in.local_day = day_v - 5'd1;
         end
      end

      out_forced_in = forced_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tz_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         tz_ff        <= tz_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      if (s1_move) begin
         out_item_ff   <= out_item_in;
         out_forced_ff <= out_forced_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_item_ff};
   assign rsp_tuser  = out_forced_ff;

   `RTCBCD_ASSERT_NEXT(a_s1_hold, s1_valid_ff && !out_open,
      s1_valid_ff && $stable(s1_item_ff), "stalled item in input register changed or dropped")
   `RTCBCD_ASSERT_NEXT(a_s1_load, req_take, s1_valid_ff, "accepted item not held in input register")
   `RTCBCD_ASSERT_NOW(a_hour_range, rsp_tvalid, out_item_ff.local_hour <= 5'd23,
      "local hour out of range")
   `RTCBCD_ASSERT_NOW(a_date_range, rsp_tvalid,
      (out_item_ff.local_day != 5'd0) && (out_item_ff.local_month != 4'd0) &&
      (out_item_ff.local_month <= 4'd12), "local date out of range")

endmodule
